// File: rtl/nstc_pkg.sv
// nstc_pkg: shared widths, constant tables and the word types of the solar term countdown
// used by the channel interfaces, the front end, the term cells and the top level
`default_nettype none

package nstc_pkg;

   localparam int NUM_TERMS   = 24;
   localparam int TABLE_YEARS = 11;
   localparam int YEAR_W      = 12;
   localparam int MONTH_W     = 4;
   localparam int DAY_W       = 5;
   localparam int TERM_W      = 5;
   localparam int DAYS_W      = 9;

   localparam logic [11:0] BASE_YEAR        = 12'd1900;
   localparam logic [11:0] TABLE_YEAR_FIRST = 12'd2026;
   localparam logic [11:0] TABLE_YEAR_LAST  = 12'd2036;
   localparam logic [8:0]  YEAR_DAYS        = 9'd365;
   localparam logic [8:0]  NO_DIFF          = 9'd366;

   // fixed point divide by ten thousand
   localparam logic [11:0] MUL_COEF    = 12'd2422;
   localparam logic [13:0] DIVISOR     = 14'd10000;
   localparam logic [9:0]  BIAS_QUOT   = 10'd461;
   localparam logic [23:0] DIV_BIAS    = 24'd4610000;
   localparam logic [10:0] RECIP       = 11'd1677;
   localparam int          RECIP_SHIFT = 24;

   localparam logic [4:0] TERM_EARLY_JAN = 5'd0;
   localparam logic [4:0] TERM_EARLY_FEB = 5'd2;
   localparam logic [4:0] TERM_MID_FEB   = 5'd3;

   // per-term constant split as whole days and the fraction times ten thousand
   localparam logic [4:0] COEF_HI [NUM_TERMS] = '{
      5'd6,  5'd21, 5'd4,  5'd19, 5'd6,  5'd21, 5'd5,  5'd20,
      5'd6,  5'd21, 5'd6,  5'd22, 5'd7,  5'd23, 5'd8,  5'd23,
      5'd8,  5'd23, 5'd9,  5'd24, 5'd8,  5'd23, 5'd7,  5'd22
   };

   localparam logic [13:0] COEF_LO [NUM_TERMS] = '{
      14'd700,  14'd1500, 14'd8500, 14'd1000, 14'd3900, 14'd2500, 14'd6500, 14'd8900,
      14'd1500, 14'd8900, 14'd3900, 14'd1500, 14'd8900, 14'd4900, 14'd1500, 14'd8900,
      14'd3900, 14'd8900, 14'd1500, 14'd1500, 14'd1500, 14'd1500, 14'd8900, 14'd6500
   };

   localparam logic [8:0] MONTH_START [16] = '{
      9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd334, 9'd334, 9'd334
   };

   localparam logic [4:0] FIXED_JAN [TABLE_YEARS] = '{
      5'd5, 5'd5, 5'd6, 5'd5, 5'd5, 5'd5, 5'd6, 5'd5, 5'd5, 5'd5, 5'd6
   };
   localparam logic [4:0] FIXED_FEB_EARLY [TABLE_YEARS] = '{
      5'd4, 5'd4, 5'd4, 5'd3, 5'd4, 5'd4, 5'd4, 5'd3, 5'd4, 5'd4, 5'd4
   };
   localparam logic [4:0] FIXED_FEB_MID [TABLE_YEARS] = '{
      5'd18, 5'd18, 5'd19, 5'd18, 5'd18, 5'd19, 5'd19, 5'd18, 5'd18, 5'd19, 5'd19
   };

   typedef struct packed {
      logic signed [7:0] base;
      logic [13:0]       rem;
      logic              tbl_hit;
      logic [3:0]        tbl_idx;
      logic [8:0]        today;
      logic [4:0]        lead_term;
      logic [8:0]        lead_days;
   } ctx_type;

   typedef struct packed {
      logic    valid;
      ctx_type ctx;
   } link_type;

   function automatic logic has_table(input logic [4:0] idx);
      return idx inside {TERM_EARLY_JAN, TERM_EARLY_FEB, TERM_MID_FEB};
   endfunction

   function automatic logic [4:0] fixed_day(input logic [4:0] idx, input logic [3:0] yi);
      logic [4:0] d;
      d = '0;
      if (yi < 4'(TABLE_YEARS)) begin
         case (idx)
            TERM_EARLY_JAN: d = FIXED_JAN[yi];
            TERM_EARLY_FEB: d = FIXED_FEB_EARLY[yi];
            TERM_MID_FEB:   d = FIXED_FEB_MID[yi];
            default:        d = '0;
         endcase
      end
      return d;
   endfunction

   function automatic logic [8:0] term_month_start(input logic [4:0] idx);
      logic [3:0] m;
      m = idx[4:1] + 4'd1;
      return MONTH_START[m];
   endfunction

endpackage

`default_nettype wire

// File: rtl/nstc_if.sv
// nstc_if: request and response channel interfaces, valid/ready with payload
// depends on nstc_pkg for field widths
`default_nettype none

interface nstc_req_if;
   logic                           valid;
   logic                           ready;
   logic [nstc_pkg::YEAR_W-1:0]    year;
   logic [nstc_pkg::MONTH_W-1:0]   month;
   logic [nstc_pkg::DAY_W-1:0]     day;

   modport source (output valid, year, month, day, input ready);
   modport sink   (input valid, year, month, day, output ready);
endinterface

interface nstc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [nstc_pkg::TERM_W-1:0]    next_term;
   logic [nstc_pkg::DAYS_W-1:0]    days_until;

   modport source (output valid, next_term, days_until, input ready);
   modport sink   (input valid, next_term, days_until, output ready);
endinterface

`default_nettype wire

// File: rtl/nstc_front.sv
// nstc_front: four stage front end, year offset, divide by ten thousand, day of year
// depends on nstc_pkg and nstc_if; feeds the first term cell
`default_nettype none

module nstc_front (
   input  wire logic           clock,
   input  wire logic           reset,
   nstc_req_if.sink            req_ch,
   input  wire logic           out_ready,
   output nstc_pkg::link_type  out_link
);

   typedef struct packed {
      logic [23:0]        num;
      logic [9:0]         quot;
      logic [14:0]        rem;
      logic signed [10:0] y_quarter;
      logic [8:0]         today;
      logic               tbl_hit;
      logic [3:0]         tbl_idx;
   } pre_type;

   pre_type s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic    v1_ff, v2_ff, v3_ff;
   nstc_pkg::link_type s4_ff, s4_in;
   logic    ld1, ld2, ld3, ld4;

   logic signed [12:0] y_s;
   logic signed [12:0] coef_s;
   logic signed [25:0] prod;
   logic [25:0]        biased;
   logic [34:0]        qprod;
   logic [23:0]        qmul;
   logic               fix;
   logic [9:0]         quot_fix;
   logic [14:0]        rem_fix;
   logic [11:0]        base_full;

   assign ld4 = !s4_ff.valid || out_ready;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign req_ch.ready = ld1;
   assign out_link = s4_ff;

   // stage 1: offset year, scale by the mean year length, bias to stay positive
   assign y_s    = $signed({1'b0, req_ch.year}) - $signed({1'b0, nstc_pkg::BASE_YEAR});
   assign coef_s = $signed({1'b0, nstc_pkg::MUL_COEF});
   assign prod   = y_s * coef_s;
   assign biased = 26'(prod) + {2'b00, nstc_pkg::DIV_BIAS};

   always_comb begin
      s1_in           = '0;
      s1_in.num       = biased[23:0];
      s1_in.y_quarter = y_s[12:2];
      s1_in.today     = nstc_pkg::MONTH_START[req_ch.month] + {4'b0, req_ch.day};
      s1_in.tbl_hit   = (req_ch.year >= nstc_pkg::TABLE_YEAR_FIRST)
                        && (req_ch.year <= nstc_pkg::TABLE_YEAR_LAST);
      s1_in.tbl_idx   = 4'(req_ch.year - nstc_pkg::TABLE_YEAR_FIRST);
   end

   // stage 2: quotient estimate, low by at most one
   assign qprod = {11'b0, s1_ff.num} * {24'b0, nstc_pkg::RECIP};

   always_comb begin
      s2_in      = s1_ff;
      s2_in.quot = qprod[nstc_pkg::RECIP_SHIFT +: 10];
   end

   // stage 3: remainder of the estimate
   assign qmul = {14'b0, s2_ff.quot} * {10'b0, nstc_pkg::DIVISOR};

   always_comb begin
      s3_in     = s2_ff;
      s3_in.rem = 15'(s2_ff.num - qmul);
   end

   // stage 4: correct the estimate, remove bias and the leap day share
   assign fix      = s3_ff.rem >= {1'b0, nstc_pkg::DIVISOR};
   assign quot_fix = s3_ff.quot + {9'b0, fix};
   assign rem_fix  = fix ? (s3_ff.rem - {1'b0, nstc_pkg::DIVISOR}) : s3_ff.rem;
   assign base_full = {2'b00, quot_fix} - {2'b00, nstc_pkg::BIAS_QUOT}
                      - {s3_ff.y_quarter[10], s3_ff.y_quarter};

   always_comb begin
      s4_in               = '0;
      s4_in.valid         = v3_ff;
      s4_in.ctx.base      = base_full[7:0];
      s4_in.ctx.rem       = rem_fix[13:0];
      s4_in.ctx.tbl_hit   = s3_ff.tbl_hit;
      s4_in.ctx.tbl_idx   = s3_ff.tbl_idx;
      s4_in.ctx.today     = s3_ff.today;
      s4_in.ctx.lead_term = '0;
      s4_in.ctx.lead_days = nstc_pkg::NO_DIFF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else begin
         if (ld1) begin
            v1_ff <= req_ch.valid;
            s1_ff <= s1_in;
         end
         if (ld2) begin
            v2_ff <= v1_ff;
            s2_ff <= s2_in;
         end
         if (ld3) begin
            v3_ff <= v2_ff;
            s3_ff <= s3_in;
         end
         if (ld4) begin
            s4_ff <= s4_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/nstc_cell.sv
// nstc_cell: one solar term, computes its day of year and folds it into the running best
// depends on nstc_pkg; cells are chained, one per term
`default_nettype none

module nstc_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [4:0]          term_no,
   input  wire nstc_pkg::link_type  in_link,
   output logic                     in_ready,
   output nstc_pkg::link_type       out_link,
   input  wire logic                out_ready
);

   nstc_pkg::link_type link_ff, link_in;

   logic [14:0] sum_lo;
   logic        carry;
   logic [9:0]  formula_day;
   logic [9:0]  day_sel;
   logic [10:0] term_doy;
   logic [10:0] diff;
   logic [10:0] diff_a;
   logic [10:0] diff_b;
   logic [10:0] wrapped;
   logic [8:0]  wrap9;
   logic        better;

   assign in_ready = !link_ff.valid || out_ready;
   assign out_link = link_ff;

   // fractional part of the term constant may carry into the day
   assign sum_lo = {1'b0, in_link.ctx.rem} + {1'b0, nstc_pkg::COEF_LO[term_no]};
   assign carry  = sum_lo >= {1'b0, nstc_pkg::DIVISOR};

   assign formula_day = {{2{in_link.ctx.base[7]}}, in_link.ctx.base}
                        + {5'b0, nstc_pkg::COEF_HI[term_no]} + {9'b0, carry};
   assign day_sel = (nstc_pkg::has_table(term_no) && in_link.ctx.tbl_hit)
                    ? {5'b0, nstc_pkg::fixed_day(term_no, in_link.ctx.tbl_idx)}
                    : formula_day;

   assign term_doy = {2'b00, nstc_pkg::term_month_start(term_no)} + {day_sel[9], day_sel};
   assign diff     = term_doy - {2'b00, in_link.ctx.today};

   // wrap into next year, twice at most for out of range dates
   assign diff_a  = diff + {2'b00, nstc_pkg::YEAR_DAYS};
   assign diff_b  = diff + {1'b0, nstc_pkg::YEAR_DAYS, 1'b0};
   assign wrapped = !diff[10] ? diff : (!diff_a[10] ? diff_a : diff_b);
   assign wrap9   = wrapped[8:0];
   assign better  = wrap9 < in_link.ctx.lead_days;

   always_comb begin
      link_in       = in_link;
      if (better) begin
         link_in.ctx.lead_days = wrap9;
         link_in.ctx.lead_term = term_no;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else if (in_ready) begin
         link_ff <= link_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/next_solar_term_countdown_core.sv
// Next solar term countdown: takes a year, month and day word and returns the index of the
// nearest upcoming solar term (0 is the early-January term) and the days until it, 0 meaning
// today. Leap years are ignored and dates are not checked. One word is accepted and one
// result word leaves per clock while the response side does not stall; each result passes
// through the 4 front end stages, then one stage in each of the 24 term cells. Every stage
// has its own valid bit so bubbles close up behind a stalled output. There are no
// configuration registers and no state beyond the pipeline.
// depends on nstc_pkg, nstc_if, nstc_front and nstc_cell
`default_nettype none

module next_solar_term_countdown_core (
   input  wire logic  clock,
   input  wire logic  reset,
   nstc_req_if.sink   req_ch,
   nstc_rsp_if.source rsp_ch
);

   nstc_pkg::link_type link [nstc_pkg::NUM_TERMS+1];
   logic               ready_chain [nstc_pkg::NUM_TERMS+1];

   nstc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_ready (ready_chain[0]),
      .out_link  (link[0])
   );

   for (genvar i = 0; i < nstc_pkg::NUM_TERMS; i++) begin : g_cell
      nstc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .term_no   (5'(i)),
         .in_link   (link[i]),
         .in_ready  (ready_chain[i]),
         .out_link  (link[i+1]),
         .out_ready (ready_chain[i+1])
      );
   end

   assign ready_chain[nstc_pkg::NUM_TERMS] = rsp_ch.ready;
   assign rsp_ch.valid      = link[nstc_pkg::NUM_TERMS].valid;
   assign rsp_ch.next_term  = link[nstc_pkg::NUM_TERMS].ctx.lead_term;
   assign rsp_ch.days_until = link[nstc_pkg::NUM_TERMS].ctx.lead_days;

   // corrected remainder must be a true remainder
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      link[0].valid |-> (link[0].ctx.rem < nstc_pkg::DIVISOR))
      else $error("front end remainder not below divisor");

   // cell chain starts from an empty best
   a_seed: assert property (@(posedge clock) disable iff (reset)
      link[0].valid |-> (link[0].ctx.lead_days == nstc_pkg::NO_DIFF
                         && link[0].ctx.lead_term == '0))
      else $error("cell chain seeded with a stale best");

   // some term always beats the empty best
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.days_until <= nstc_pkg::YEAR_DAYS
                        && rsp_ch.next_term < 5'(nstc_pkg::NUM_TERMS)))
      else $error("result out of range");

endmodule

`default_nettype wire
